[rtl/midi_parser_with_control_mapping_assert.svh]
// assertion macros for the midi parser checker
// expects clk and arst_n in the scope of use
`ifndef MIDI_PARSER_WITH_CONTROL_MAPPING_ASSERT_SVH
`define MIDI_PARSER_WITH_CONTROL_MAPPING_ASSERT_SVH

// same-cycle implication
`define MPCM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mpcm assertion failed");

// next-cycle implication
`define MPCM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mpcm assertion failed");

`endif

[rtl/mpcm_pkg.sv]
// shared types, codes and helpers of the midi parser with control mapping
// no dependencies
`timescale 1ns / 1ps

package mpcm_pkg;

	localparam int MPCM_QUEUE_DEPTH = 2;

	localparam logic [7:0] ST_REALTIME_MIN = 8'hF8;
	localparam logic [7:0] ST_SYSEX        = 8'hF0;

	localparam logic [3:0] TYPE_NOTE_OFF   = 4'h8;
	localparam logic [3:0] TYPE_NOTE_ON    = 4'h9;
	localparam logic [3:0] TYPE_CC         = 4'hB;
	localparam logic [3:0] TYPE_PROGRAM    = 4'hC;
	localparam logic [3:0] TYPE_CHAN_PRESS = 4'hD;
	localparam logic [3:0] TYPE_BEND       = 4'hE;

	localparam logic KIND_MSG  = 1'b0;
	localparam logic KIND_DROP = 1'b1;

	localparam logic MODE_ABS    = 1'b0;
	localparam logic MODE_TOGGLE = 1'b1;

	localparam logic [8:0] PARAM_BEND  = 9'd256;
	localparam logic [8:0] NOTE_OFFSET = 9'd128;

	typedef struct packed {
		logic       kind;
		logic [7:0] status;
		logic [6:0] d1;
		logic [6:0] d2;
	} msg_t;

	// round(d * 65536 / 127): 65536 = 127 * 516 + 4, so the quotient is
	// d * 516 plus (4 * d + 63) / 127, which stays below 5
	function automatic logic [16:0] scale127(input logic [6:0] d);
		logic [9:0]  r;
		logic [2:0]  q;
		logic [16:0] base;
		r = {1'b0, d, 2'b00} + 10'd63;
		q = 3'(r >= 10'd127) + 3'(r >= 10'd254) + 3'(r >= 10'd381) + 3'(r >= 10'd508);
		base = 17'(d) * 17'd516;
		return base + 17'(q);
	endfunction

endpackage

[rtl/mpcm_queue.sv]
// small message queue between parser front and mapping back
// depends on mpcm_pkg
`timescale 1ns / 1ps

module mpcm_queue
	import mpcm_pkg::*;
#(
	parameter int DEPTH = MPCM_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  msg_t wr_msg,
	output logic full,
	input  logic rd,
	output msg_t rd_msg,
	output logic nempty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	msg_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	assign full   = (cnt_q == CW'(DEPTH));
	assign nempty = (cnt_q != '0);
	assign rd_msg = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_msg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/mpcm_front.sv]
// byte parser: running status, data gathering, drop classification
// depends on mpcm_pkg
`timescale 1ns / 1ps

module mpcm_front
	import mpcm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] rx_byte,
	input  logic       full,
	output logic       wr,
	output msg_t       wr_msg
);

	logic [7:0] rs_q;
	logic [6:0] held_q;
	logic       held_v_q;
	logic       sysex_q;

	logic [7:0] rs_d;
	logic [6:0] held_d;
	logic       held_v_d;
	logic       sysex_d;
	logic       emit;
	logic       fire;
	logic [3:0] rs_type;

	assign fire    = push && !full;
	assign rs_type = rs_q[7:4];
	assign wr      = fire && emit;

	always_comb begin
		rs_d     = rs_q;
		held_d   = held_q;
		held_v_d = held_v_q;
		sysex_d  = sysex_q;
		emit     = 1'b0;
		wr_msg   = '{kind: KIND_DROP, status: rx_byte, d1: '0, d2: '0};
		priority if (rx_byte >= ST_REALTIME_MIN) begin
			emit = 1'b1;
		end else if (rx_byte >= ST_SYSEX) begin
			// system common or sysex start
			rs_d     = '0;
			held_d   = '0;
			held_v_d = 1'b0;
			sysex_d  = (rx_byte == ST_SYSEX);
			emit     = 1'b1;
		end else if (rx_byte[7]) begin
			rs_d     = rx_byte;
			held_d   = '0;
			held_v_d = 1'b0;
			sysex_d  = 1'b0;
		end else if (sysex_q) begin
			emit = 1'b0;
		end else if (rs_q == '0) begin
			emit = 1'b1;
		end else if (rs_type == TYPE_PROGRAM || rs_type == TYPE_CHAN_PRESS) begin
			emit   = 1'b1;
			wr_msg = '{kind: KIND_MSG, status: rs_q, d1: rx_byte[6:0], d2: '0};
		end else if (!held_v_q) begin
			held_d   = rx_byte[6:0];
			held_v_d = 1'b1;
		end else begin
			emit     = 1'b1;
			wr_msg   = '{kind: KIND_MSG, status: rs_q, d1: held_q, d2: rx_byte[6:0]};
			held_d   = '0;
			held_v_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q     <= '0;
			held_q   <= '0;
			held_v_q <= 1'b0;
			sysex_q  <= 1'b0;
		end else if (fire) begin
			rs_q     <= rs_d;
			held_q   <= held_d;
			held_v_q <= held_v_d;
			sysex_q  <= sysex_d;
		end
	end

endmodule

[rtl/mpcm_back.sv]
// control mapping and output register
// depends on mpcm_pkg
`timescale 1ns / 1ps

module mpcm_back
	import mpcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  msg_t        head,
	input  logic        head_valid,
	output logic        rd,
	input  logic        pop,
	output logic        empty,
	output logic        kind,
	output logic [7:0]  status_byte,
	output logic [3:0]  channel,
	output logic [6:0]  data_first,
	output logic [6:0]  data_second,
	output logic        event_valid,
	output logic [8:0]  control_id,
	output logic        event_mode,
	output logic [16:0] event_value
);

	logic        out_v_q;
	logic        kind_q;
	logic [7:0]  status_q;
	logic [6:0]  d1_q;
	logic [6:0]  d2_q;
	logic        ev_q;
	logic [8:0]  pid_q;
	logic        mode_q;
	logic [16:0] val_q;

	logic        ev_d;
	logic [8:0]  pid_d;
	logic        mode_d;
	logic [16:0] val_d;
	logic [3:0]  mtype;

	assign rd    = head_valid && (!out_v_q || pop);
	assign mtype = head.status[7:4];

	always_comb begin
		ev_d   = 1'b0;
		pid_d  = '0;
		mode_d = MODE_ABS;
		val_d  = '0;
		if (head.kind == KIND_MSG) begin
			unique case (mtype)
				TYPE_CC: begin
					ev_d  = 1'b1;
					pid_d = 9'(head.d1);
					val_d = scale127(head.d2);
				end
				TYPE_NOTE_ON: begin
					ev_d   = 1'b1;
					pid_d  = 9'(head.d1) + NOTE_OFFSET;
					mode_d = MODE_TOGGLE;
					val_d  = scale127(head.d2);
				end
				TYPE_NOTE_OFF: begin
					ev_d   = 1'b1;
					pid_d  = 9'(head.d1) + NOTE_OFFSET;
					mode_d = MODE_TOGGLE;
				end
				TYPE_BEND: begin
					ev_d  = 1'b1;
					pid_d = PARAM_BEND;
					val_d = {1'b0, head.d2, head.d1, 2'b00};
				end
				default: begin
					ev_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rd) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			kind_q   <= head.kind;
			status_q <= head.status;
			d1_q     <= head.d1;
			d2_q     <= head.d2;
			ev_q     <= ev_d;
			pid_q    <= pid_d;
			mode_q   <= mode_d;
			val_q    <= val_d;
		end
	end

	assign empty       = !out_v_q;
	assign kind        = kind_q;
	assign status_byte = status_q;
	assign channel     = status_q[3:0];
	assign data_first  = d1_q;
	assign data_second = d2_q;
	assign event_valid = ev_q;
	assign control_id  = pid_q;
	assign event_mode  = mode_q;
	assign event_value = val_q;

endmodule

[rtl/midi_parser_with_control_mapping.sv]
// channel  | handshake    | payload
// input    | push / full  | rx_byte
// result   | pop / empty  | kind status_byte channel data_first data_second
//          |              | event_valid control_id event_mode event_value
// one byte accepted per cycle unless full; a result passes the queue, then the output register
// the parser front writes the message queue, the mapping back drains it
// full rises only when the queue is full while the output register holds
// arst_n clears running status, the queue and the output register
// top level; depends on mpcm_pkg, mpcm_front, mpcm_queue, mpcm_back
`timescale 1ns / 1ps

module midi_parser_with_control_mapping
	import mpcm_pkg::*;
#(
	parameter int QUEUE_DEPTH = MPCM_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [7:0]  status_byte,
	output logic [3:0]  channel,
	output logic [6:0]  data_first,
	output logic [6:0]  data_second,
	output logic        event_valid,
	output logic [8:0]  control_id,
	output logic        event_mode,
	output logic [16:0] event_value
);

	logic q_wr;
	msg_t q_wr_msg;
	logic q_rd;
	msg_t q_head;
	logic q_nempty;

	mpcm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.full    (full),
		.wr      (q_wr),
		.wr_msg  (q_wr_msg)
	);

	mpcm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_msg (q_wr_msg),
		.full   (full),
		.rd     (q_rd),
		.rd_msg (q_head),
		.nempty (q_nempty)
	);

	mpcm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.head_valid  (q_nempty),
		.rd          (q_rd),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind),
		.status_byte (status_byte),
		.channel     (channel),
		.data_first  (data_first),
		.data_second (data_second),
		.event_valid (event_valid),
		.control_id  (control_id),
		.event_mode  (event_mode),
		.event_value (event_value)
	);

endmodule

[rtl/mpcm_checker.sv]
// port-level checks on the midi parser top level, with its bind
// depends on mpcm_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "midi_parser_with_control_mapping_assert.svh"

module mpcm_checker
	import mpcm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [7:0]  rx_byte,
	input logic        empty,
	input logic        pop,
	input logic        kind,
	input logic [7:0]  status_byte,
	input logic [3:0]  channel,
	input logic [6:0]  data_first,
	input logic [6:0]  data_second,
	input logic        event_valid,
	input logic [8:0]  control_id,
	input logic        event_mode,
	input logic [16:0] event_value
);

	// a waiting transaction holds until taken
	`MPCM_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(status_byte) && $stable(event_value))

	`MPCM_ASSERT_NOW(a_chan, !empty, channel == status_byte[3:0])

	`MPCM_ASSERT_NOW(a_drop, !empty && kind == KIND_DROP, data_first == '0 && data_second == '0 && !event_valid)

	`MPCM_ASSERT_NOW(a_noev, !empty && !event_valid, control_id == '0 && event_mode == MODE_ABS && event_value == '0)

	`MPCM_ASSERT_NOW(a_bend, !empty && event_valid && control_id == PARAM_BEND, event_mode == MODE_ABS && event_value[1:0] == 2'b00)

endmodule

bind midi_parser_with_control_mapping mpcm_checker u_mpcm_checker (.*);

[verif/midi_parser_with_control_mapping_tb.sv]
// testbench for midi_parser_with_control_mapping: byte stream in, parsed messages out
// self-checking against an in-file parser model; depends on mpcm_pkg and the rtl top
`timescale 1ns / 1ps

module midi_parser_with_control_mapping_tb;
	import mpcm_pkg::*;

	localparam int RANDOM_BYTES = 1725;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int CALM_FROM = 600;
	localparam int CALM_TO = 1100;
	localparam logic [7:0] NO_STATUS = 8'h00;
	localparam logic [7:0] ST_COMMON_MIN = 8'hF1;
	localparam logic [7:0] ST_COMMON_MAX = 8'hF7;
	localparam logic [7:0] ST_REALTIME_MAX = 8'hFF;

	typedef struct packed {
		logic        kind;
		logic [7:0]  status;
		logic [3:0]  chan;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic        ev;
		logic [8:0]  param;
		logic        mode;
		logic [16:0] value;
	} midi_result_t;

	typedef struct packed {
		logic [7:0]   rx;
		logic         fixed;
		midi_result_t want;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic        kind;
	logic [7:0]  status_byte;
	logic [3:0]  channel;
	logic [6:0]  data_first;
	logic [6:0]  data_second;
	logic        event_valid;
	logic [8:0]  control_id;
	logic        event_mode;
	logic [16:0] event_value;

	midi_result_t pending_results[$];
	stim_t        byte_stream[$];
	stim_t        directed_rows[25];
	int           failures = 0;
	int           random_items = 0;
	int unsigned  cycle_count = 0;

	// parser state
	logic [7:0] live_status = NO_STATUS;
	logic [6:0] held_byte = 7'd0;
	logic       byte_held = 1'b0;
	logic       sysex_open = 1'b0;

	midi_parser_with_control_mapping u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.status_byte (status_byte),
		.channel     (channel),
		.data_first  (data_first),
		.data_second (data_second),
		.event_valid (event_valid),
		.control_id  (control_id),
		.event_mode  (event_mode),
		.event_value (event_value)
	);

	initial forever #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic logic calm_stretch();
		return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
	endfunction

	function automatic logic [16:0] to_q16(input logic [6:0] d);
		return 17'((int'(d) * 65536 + 63) / 127);
	endfunction

	function automatic midi_result_t dropped(input logic [7:0] b);
		midi_result_t r;
		r = '0;
		r.kind = KIND_DROP;
		r.status = b;
		r.chan = b[3:0];
		return r;
	endfunction

	function automatic midi_result_t message(input logic [7:0] st, input logic [6:0] d1,
			input logic [6:0] d2);
		midi_result_t r;
		r = '0;
		r.kind = KIND_MSG;
		r.status = st;
		r.chan = st[3:0];
		r.d1 = d1;
		r.d2 = d2;
		case (st[7:4])
			TYPE_CC: begin
				r.ev = 1'b1;
				r.param = 9'(d1);
				r.mode = MODE_ABS;
				r.value = to_q16(d2);
			end
			TYPE_NOTE_ON: begin
				r.ev = 1'b1;
				r.param = NOTE_OFFSET + 9'(d1);
				r.mode = MODE_TOGGLE;
				r.value = to_q16(d2);
			end
			TYPE_NOTE_OFF: begin
				r.ev = 1'b1;
				r.param = NOTE_OFFSET + 9'(d1);
				r.mode = MODE_TOGGLE;
			end
			TYPE_BEND: begin
				r.ev = 1'b1;
				r.param = PARAM_BEND;
				r.mode = MODE_ABS;
				r.value = 17'({d2, d1}) << 2;
			end
			default: ;
		endcase
		return r;
	endfunction

	// returns 1 when the byte completes a result
	function automatic logic parse_byte(input logic [7:0] b, output midi_result_t r);
		logic [6:0] first;
		r = '0;
		if (b >= ST_REALTIME_MIN) begin
			r = dropped(b);
			return 1'b1;
		end
		if (b >= ST_SYSEX) begin
			live_status = NO_STATUS;
			byte_held = 1'b0;
			held_byte = 7'd0;
			sysex_open = (b == ST_SYSEX);
			r = dropped(b);
			return 1'b1;
		end
		if (b[7]) begin
			live_status = b;
			byte_held = 1'b0;
			held_byte = 7'd0;
			sysex_open = 1'b0;
			return 1'b0;
		end
		if (sysex_open)
			return 1'b0;
		if (live_status == NO_STATUS) begin
			r = dropped(b);
			return 1'b1;
		end
		if (live_status[7:4] == TYPE_PROGRAM || live_status[7:4] == TYPE_CHAN_PRESS) begin
			r = message(live_status, b[6:0], 7'd0);
			return 1'b1;
		end
		if (!byte_held) begin
			held_byte = b[6:0];
			byte_held = 1'b1;
			return 1'b0;
		end
		first = held_byte;
		byte_held = 1'b0;
		held_byte = 7'd0;
		r = message(live_status, first, b[6:0]);
		return 1'b1;
	endfunction

	function automatic logic [6:0] data_value();
		case ($urandom_range(9))
			0: return 7'd0;
			1: return 7'h7F;
			default: return 7'($urandom);
		endcase
	endfunction

	task automatic add_byte(input logic [7:0] b, input logic tally);
		byte_stream.push_back('{b, 1'b0, '0});
		if (tally)
			random_items++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	// result side
	always @(negedge clk) begin
		pop <= calm_stretch() || $urandom_range(99) >= 16;
	end

	always @(posedge clk) begin
		midi_result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected, status_byte %0h", status_byte);
				failures++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", want.kind, kind);
				check_field("status_byte", want.status, status_byte);
				check_field("channel", want.chan, channel);
				check_field("data_first", want.d1, data_first);
				check_field("data_second", want.d2, data_second);
				check_field("event_valid", want.ev, event_valid);
				check_field("control_id", want.param, control_id);
				check_field("event_mode", want.mode, event_mode);
				check_field("event_value", want.value, event_value);
			end
		end
	end

	// watchdog: cycles without any transaction
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("midi_parser_with_control_mapping verification failed");
		$finish;
	end

	initial begin
		stim_t        row;
		midi_result_t got;
		logic         produced;
		logic [7:0]   status;
		int           dice;
		int           n;

		directed_rows = '{
			'{8'h40, 1'b1, '{KIND_DROP, 8'h40, 4'h0, 7'd0, 7'd0, 1'b0, 9'd0, MODE_ABS, 17'd0}},
			'{8'hF8, 1'b1, '{KIND_DROP, 8'hF8, 4'h8, 7'd0, 7'd0, 1'b0, 9'd0, MODE_ABS, 17'd0}},
			'{8'hFF, 1'b1, '{KIND_DROP, 8'hFF, 4'hF, 7'd0, 7'd0, 1'b0, 9'd0, MODE_ABS, 17'd0}},
			'{8'h90, 1'b0, '0},
			'{8'h3C, 1'b0, '0},
			'{8'hFE, 1'b1, '{KIND_DROP, 8'hFE, 4'hE, 7'd0, 7'd0, 1'b0, 9'd0, MODE_ABS, 17'd0}},
			'{8'h7F, 1'b1,
				'{KIND_MSG, 8'h90, 4'h0, 7'h3C, 7'h7F, 1'b1, 9'd188, MODE_TOGGLE, 17'd65536}},
			'{8'h00, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'h8F, 1'b0, '0},
			'{8'h7F, 1'b0, '0},
			'{8'h40, 1'b0, '0},
			'{8'hBA, 1'b0, '0},
			'{8'h07, 1'b0, '0},
			'{8'hC5, 1'b0, '0},
			'{8'h12, 1'b0, '0},
			'{8'hE3, 1'b0, '0},
			'{8'h7F, 1'b0, '0},
			'{8'h7F, 1'b1,
				'{KIND_MSG, 8'hE3, 4'h3, 7'h7F, 7'h7F, 1'b1, PARAM_BEND, MODE_ABS, 17'd65532}},
			'{8'hF0, 1'b1, '{KIND_DROP, 8'hF0, 4'h0, 7'd0, 7'd0, 1'b0, 9'd0, MODE_ABS, 17'd0}},
			'{8'h55, 1'b0, '0},
			'{8'hD7, 1'b0, '0},
			'{8'h64, 1'b0, '0},
			'{8'hF7, 1'b1, '{KIND_DROP, 8'hF7, 4'h7, 7'd0, 7'd0, 1'b0, 9'd0, MODE_ABS, 17'd0}},
			'{8'h22, 1'b0, '0}
		};
		foreach (directed_rows[i])
			byte_stream.push_back(directed_rows[i]);

		while (random_items < RANDOM_BYTES) begin
			dice = $urandom_range(99);
			if (dice < 70) begin
				status = {1'b1, 3'($urandom_range(6)), 4'($urandom)};
				if ($urandom_range(3) != 0)
					add_byte(status, 1'b1);
				n = (status[7:4] == TYPE_PROGRAM || status[7:4] == TYPE_CHAN_PRESS) ? 1 : 2;
				// cut short now and then
				if ($urandom_range(19) == 0)
					n--;
				repeat (n) begin
					if ($urandom_range(9) == 0)
						add_byte(8'($urandom_range(ST_REALTIME_MAX, ST_REALTIME_MIN)), 1'b1);
					add_byte({1'b0, data_value()}, 1'b1);
				end
			end else if (dice < 78) begin
				add_byte(8'($urandom_range(ST_REALTIME_MAX, ST_REALTIME_MIN)), 1'b1);
			end else if (dice < 86) begin
				add_byte(ST_SYSEX, 1'b1);
				repeat ($urandom_range(6))
					add_byte({1'b0, 7'($urandom)}, 1'b1);
			end else if (dice < 92) begin
				add_byte(8'($urandom_range(ST_COMMON_MAX, ST_COMMON_MIN)), 1'b1);
			end else begin
				add_byte(8'($urandom), 1'b1);
			end
		end

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		while (byte_stream.size() != 0) begin
			@(negedge clk);
			if (!calm_stretch() && $urandom_range(99) < 16) begin
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				rx_byte <= byte_stream[0].rx;
			end
			@(posedge clk);
			if (push && !full) begin
				row = byte_stream.pop_front();
				produced = parse_byte(row.rx, got);
				if (row.fixed)
					pending_results.push_back(row.want);
				else if (produced)
					pending_results.push_back(got);
			end
		end
		@(negedge clk);
		push <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("midi_parser_with_control_mapping verification clean");
		else
			$display("midi_parser_with_control_mapping verification failed");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/mpcm_pkg.sv
rtl/mpcm_queue.sv
rtl/mpcm_front.sv
rtl/mpcm_back.sv
rtl/midi_parser_with_control_mapping.sv
rtl/mpcm_checker.sv
verif/midi_parser_with_control_mapping_tb.sv
